>>> hdl/rvp_pkg.sv
// shared types, constants and width helpers for the radial vignette pixel core
// no dependencies
`timescale 1ns / 1ps

package rvp_pkg;

    localparam int COL_W        = 12;
    localparam int CH_W         = 8;
    localparam int CFG_W        = 13;
    localparam int GAIN_W       = 16;
    localparam int FRAC_SQ_W    = 16;
    localparam int MAX_SIDE_DEF = 4096;

    localparam logic [CFG_W-1:0]  WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0]  HEIGHT_RST = 13'd480;
    localparam logic [GAIN_W-1:0] GAIN_HALF  = 16'h8000;
    localparam logic [CH_W-1:0]   CH_MAX     = 8'hFF;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [COL_W-1:0] row;
        logic [CH_W-1:0]  blue_in;
        logic [CH_W-1:0]  green_in;
        logic [CH_W-1:0]  red_in;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] red_out;
    } t_pix_out;

    typedef struct packed {
        t_reg_idx         index;
        logic [CFG_W-1:0] value;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic pass;
    } t_geom_stat;

    // width of the frame center coordinate
    function automatic int half_w(input int side);
        return $clog2(side + 1) - 1;
    endfunction

    // width of a pixel-to-center offset
    function automatic int dx_w(input int side);
        return (half_w(side) > COL_W) ? half_w(side) : COL_W;
    endfunction

    // width of a distance in Q.8
    function automatic int root_w(input int side);
        return (2 * dx_w(side) + 1 + FRAC_SQ_W + 1) >> 1;
    endfunction

endpackage

>>> hdl/rvp_chan_if.sv
// valid/ready channel carrying one word of type T
// depends on nothing; instantiated with types from rvp_pkg
`timescale 1ns / 1ps

interface rvp_chan_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> hdl/rvp_geom.sv
// frame geometry: width/height registers, center and sequential max distance root
// depends on rvp_pkg and rvp_chan_if
`timescale 1ns / 1ps

module rvp_geom
    import rvp_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rvp_chan_if.sink                    i_cfg,
    output logic [half_w(MAX_SIDE)-1:0] o_cx,
    output logic [half_w(MAX_SIDE)-1:0] o_cy,
    output logic [root_w(MAX_SIDE)-1:0] o_maxd,
    output t_geom_stat                  o_stat
);

    localparam int HALF_W = half_w(MAX_SIDE);
    localparam int SIDE_W = HALF_W + 1;
    localparam int SQ_W   = 2 * HALF_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int ROOT_W = root_w(MAX_SIDE);
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_width;
    logic [CFG_W-1:0]   r_height;
    logic [SQ_W-1:0]    r_sqx;
    logic [SQ_W-1:0]    r_sqy;
    logic [RAD_W-1:0]   r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_pass;

    logic [SIDE_W-1:0]  w_lim_w;
    logic [SIDE_W-1:0]  w_lim_h;
    logic [SUM_W-1:0]   w_sum;
    logic [REM_W-1:0]   w_try_rem;
    logic [REM_W-1:0]   w_try;
    logic               w_ge;

    // side limit
    always_comb begin
        if (32'(r_width) > MAX_SIDE) begin
            w_lim_w = SIDE_W'(MAX_SIDE);
        end else begin
            w_lim_w = SIDE_W'(r_width);
        end
        if (32'(r_height) > MAX_SIDE) begin
            w_lim_h = SIDE_W'(MAX_SIDE);
        end else begin
            w_lim_h = SIDE_W'(r_height);
        end
    end

    assign o_cx = w_lim_w[SIDE_W-1:1];
    assign o_cy = w_lim_h[SIDE_W-1:1];

    assign w_sum     = SUM_W'(r_sqx) + SUM_W'(r_sqy);
    assign w_try_rem = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign w_try     = {1'b0, r_root[ROOT_W-2:0], 2'b01};
    assign w_ge      = (w_try_rem >= w_try);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_SQUARE;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                REG_WIDTH:  r_width  <= i_cfg.data.value;
                REG_HEIGHT: r_height <= i_cfg.data.value;
            endcase
            r_state <= ST_SQUARE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                end
                ST_SQUARE: begin
                    r_sqx   <= SQ_W'(o_cx) * SQ_W'(o_cx);
                    r_sqy   <= SQ_W'(o_cy) * SQ_W'(o_cy);
                    r_pass  <= (o_cx == '0) && (o_cy == '0);
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_rad   <= RAD_W'({w_sum, {FRAC_SQ_W{1'b0}}});
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= CNT_W'(ROOT_W - 1);
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    r_rad  <= r_rad << 2;
                    r_rem  <= w_ge ? (w_try_rem - w_try) : w_try_rem;
                    r_root <= {r_root[ROOT_W-2:0], w_ge};
                    if (r_cnt == '0) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;
    assign o_maxd      = r_root;
    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.pass = r_pass;

endmodule

>>> hdl/rvp_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage, with a sideband word
// depends on rvp_pkg
`timescale 1ns / 1ps

module rvp_sqrt_pipe
    import rvp_pkg::*;
#(
    parameter int ROOT_W = root_w(MAX_SIDE_DEF),
    parameter int SIDE_W = 3 * CH_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [2*ROOT_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_vld,
    output logic [ROOT_W-1:0]     o_root,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic              r_vld  [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    logic [RAD_W-1:0]  w_rad_in  [ROOT_W];
    logic [REM_W-1:0]  w_rem_in  [ROOT_W];
    logic [ROOT_W-1:0] w_root_in [ROOT_W];
    logic [SIDE_W-1:0] w_side_in [ROOT_W];
    logic [REM_W-1:0]  w_try_rem [ROOT_W];
    logic [REM_W-1:0]  w_try     [ROOT_W];
    logic              w_ge      [ROOT_W];

    always_comb begin
        w_rad_in[0]  = i_rad;
        w_rem_in[0]  = '0;
        w_root_in[0] = '0;
        w_side_in[0] = i_side;
        for (int k = 1; k < ROOT_W; k++) begin
            w_rad_in[k]  = r_rad[k-1];
            w_rem_in[k]  = r_rem[k-1];
            w_root_in[k] = r_root[k-1];
            w_side_in[k] = r_side[k-1];
        end
        for (int k = 0; k < ROOT_W; k++) begin
            w_try_rem[k] = {w_rem_in[k][ROOT_W-1:0], w_rad_in[k][RAD_W-1 -: 2]};
            w_try[k]     = {1'b0, w_root_in[k][ROOT_W-2:0], 2'b01};
            w_ge[k]      = (w_try_rem[k] >= w_try[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < ROOT_W; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_rad[k]  <= w_rad_in[k] << 2;
                r_rem[k]  <= w_ge[k] ? (w_try_rem[k] - w_try[k]) : w_try_rem[k];
                r_root[k] <= {w_root_in[k][ROOT_W-2:0], w_ge[k]};
                r_side[k] <= w_side_in[k];
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

>>> hdl/radial_vignette_pixel_core.sv
// radial vignette pixel core: distance, gain division and channel scaling pipeline
// depends on rvp_pkg, rvp_chan_if, rvp_geom and rvp_sqrt_pipe
`timescale 1ns / 1ps

// Usage:
// i_cfg takes register writes (index 0 image width, index 1 image height), always ready.
// i_pix takes one pixel word per clock while i_pix.ready is high: column, row and blue/green/red.
// o_res gives one word per pixel, in order: the three channels scaled by
// one minus the pixel distance over the corner distance, rounded half to even
// and saturated.
// The pipeline takes one pixel per clock while i_pix.ready is high.
// After reset and after every register write the max distance root runs one bit a
// cycle in the geometry unit; i_pix.ready stays low until that root is done.
// Reset loads a width of 640 and a height of 480.
// The output has a two-word buffer; when the receiver stalls, the second word
// fills and the whole pipeline freezes, nothing is lost or repeated, and
// i_pix.ready drops until the receiver takes a word.
// When max distance is zero (width and height below 2) pixels pass unchanged.
module radial_vignette_pixel_core
    import rvp_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rvp_chan_if.sink    i_cfg,
    rvp_chan_if.sink    i_pix,
    rvp_chan_if.source  o_res
);

    localparam int HALF_W = half_w(MAX_SIDE);
    localparam int DX_W   = dx_w(MAX_SIDE);
    localparam int SQ_W   = 2 * DX_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int ROOT_W = root_w(MAX_SIDE);
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int PIX_W  = 3 * CH_W;
    localparam int PROD_W = CH_W + GAIN_W;

    logic [HALF_W-1:0] w_cx;
    logic [HALF_W-1:0] w_cy;
    logic [ROOT_W-1:0] w_maxd;
    t_geom_stat        w_stat;

    logic              w_en;
    logic              w_acc;
    logic [DX_W-1:0]   w_col;
    logic [DX_W-1:0]   w_row;
    logic [DX_W-1:0]   w_cxe;
    logic [DX_W-1:0]   w_cye;
    logic [DX_W-1:0]   w_dx;
    logic [DX_W-1:0]   w_dy;

    logic              r_s1_vld;
    logic [DX_W-1:0]   r_s1_dx;
    logic [DX_W-1:0]   r_s1_dy;
    logic [PIX_W-1:0]  r_s1_ch;

    logic              r_s2_vld;
    logic [SQ_W-1:0]   r_s2_sqx;
    logic [SQ_W-1:0]   r_s2_sqy;
    logic [PIX_W-1:0]  r_s2_ch;

    logic              r_s3_vld;
    logic [SUM_W-1:0]  r_s3_sum;
    logic [PIX_W-1:0]  r_s3_ch;

    logic              w_sq_vld;
    logic [ROOT_W-1:0] w_dist;
    logic [PIX_W-1:0]  w_sq_ch;

    logic              r_s4_vld;
    logic [ROOT_W-1:0] r_s4_num;
    logic [PIX_W-1:0]  r_s4_ch;

    logic              r_dv_vld [GAIN_W];
    logic [ROOT_W-1:0] r_dv_rem [GAIN_W];
    logic [GAIN_W-1:0] r_dv_q   [GAIN_W];
    logic [PIX_W-1:0]  r_dv_ch  [GAIN_W];

    logic [ROOT_W-1:0] w_dv_rem_in [GAIN_W];
    logic [GAIN_W-1:0] w_dv_q_in   [GAIN_W];
    logic [PIX_W-1:0]  w_dv_ch_in  [GAIN_W];
    logic [ROOT_W:0]   w_dv_two    [GAIN_W];
    logic              w_dv_ge     [GAIN_W];

    logic [GAIN_W-1:0] w_gain;
    logic [PIX_W-1:0]  w_dv_ch;

    logic              r_s5_vld;
    logic [PROD_W-1:0] r_s5_prod [3];

    logic [CH_W-1:0]   w_q   [3];
    logic [GAIN_W-1:0] w_frac[3];
    logic              w_inc [3];
    logic [CH_W:0]     w_rnd [3];
    logic [CH_W-1:0]   w_chan[3];
    t_pix_out          w_res;

    logic              w_push;
    logic              w_take;
    logic              r_ov;
    t_pix_out          r_od;
    logic              r_skid_vld;
    t_pix_out          r_skid;

    rvp_geom #(
        .MAX_SIDE (MAX_SIDE)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cx    (w_cx),
        .o_cy    (w_cy),
        .o_maxd  (w_maxd),
        .o_stat  (w_stat)
    );

    // pipeline moves whenever the skid word is free
    assign w_en        = !r_skid_vld;
    assign i_pix.ready = w_en && !w_stat.busy;
    assign w_acc       = i_pix.valid && i_pix.ready;

    // offsets to center
    assign w_col = DX_W'(i_pix.data.column);
    assign w_row = DX_W'(i_pix.data.row);
    assign w_cxe = DX_W'(w_cx);
    assign w_cye = DX_W'(w_cy);
    assign w_dx  = (w_col >= w_cxe) ? (w_col - w_cxe) : (w_cxe - w_col);
    assign w_dy  = (w_row >= w_cye) ? (w_row - w_cye) : (w_cye - w_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            for (int k = 0; k < GAIN_W; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_s1_vld    <= w_acc;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld;
            r_s4_vld    <= w_sq_vld;
            r_dv_vld[0] <= r_s4_vld;
            for (int k = 1; k < GAIN_W; k++) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
            r_s5_vld    <= r_dv_vld[GAIN_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_dx  <= w_dx;
            r_s1_dy  <= w_dy;
            r_s1_ch  <= {i_pix.data.red_in, i_pix.data.green_in, i_pix.data.blue_in};
            r_s2_sqx <= SQ_W'(r_s1_dx) * SQ_W'(r_s1_dx);
            r_s2_sqy <= SQ_W'(r_s1_dy) * SQ_W'(r_s1_dy);
            r_s2_ch  <= r_s1_ch;
            r_s3_sum <= SUM_W'(r_s2_sqx) + SUM_W'(r_s2_sqy);
            r_s3_ch  <= r_s2_ch;
            r_s4_num <= (w_dist < w_maxd) ? (w_maxd - w_dist) : '0;
            r_s4_ch  <= w_sq_ch;
        end
    end

    rvp_sqrt_pipe #(
        .ROOT_W (ROOT_W),
        .SIDE_W (PIX_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s3_vld),
        .i_rad   (RAD_W'({r_s3_sum, {FRAC_SQ_W{1'b0}}})),
        .i_side  (r_s3_ch),
        .o_vld   (w_sq_vld),
        .o_root  (w_dist),
        .o_side  (w_sq_ch)
    );

    // gain = (num << 16) / maxd, one quotient bit per stage
    always_comb begin
        w_dv_rem_in[0] = r_s4_num;
        w_dv_q_in[0]   = '0;
        w_dv_ch_in[0]  = r_s4_ch;
        for (int k = 1; k < GAIN_W; k++) begin
            w_dv_rem_in[k] = r_dv_rem[k-1];
            w_dv_q_in[k]   = r_dv_q[k-1];
            w_dv_ch_in[k]  = r_dv_ch[k-1];
        end
        for (int k = 0; k < GAIN_W; k++) begin
            w_dv_two[k] = {w_dv_rem_in[k], 1'b0};
            w_dv_ge[k]  = (w_dv_two[k] >= {1'b0, w_maxd});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < GAIN_W; k++) begin
                r_dv_rem[k] <= w_dv_ge[k] ? ROOT_W'(w_dv_two[k] - {1'b0, w_maxd})
                                          : ROOT_W'(w_dv_two[k]);
                r_dv_q[k]   <= {w_dv_q_in[k][GAIN_W-2:0], w_dv_ge[k]};
                r_dv_ch[k]  <= w_dv_ch_in[k];
            end
        end
    end

    assign w_gain  = r_dv_q[GAIN_W-1];
    assign w_dv_ch = r_dv_ch[GAIN_W-1];

    // channel products, pass-through as an exact product
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_stat.pass) begin
                    r_s5_prod[i] <= {w_dv_ch[i*CH_W +: CH_W], {GAIN_W{1'b0}}};
                end else begin
                    r_s5_prod[i] <= PROD_W'(w_dv_ch[i*CH_W +: CH_W]) * PROD_W'(w_gain);
                end
            end
        end
    end

    // round half to even, saturate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_q[i]    = r_s5_prod[i][PROD_W-1:GAIN_W];
            w_frac[i] = r_s5_prod[i][GAIN_W-1:0];
            w_inc[i]  = (w_frac[i] > GAIN_HALF) || ((w_frac[i] == GAIN_HALF) && w_q[i][0]);
            w_rnd[i]  = {1'b0, w_q[i]} + {{CH_W{1'b0}}, w_inc[i]};
            w_chan[i] = w_rnd[i][CH_W] ? CH_MAX : w_rnd[i][CH_W-1:0];
        end
    end

    assign w_res.blue_out  = w_chan[0];
    assign w_res.green_out = w_chan[1];
    assign w_res.red_out   = w_chan[2];

    // output word plus skid word
    assign w_push = w_en && r_s5_vld;
    assign w_take = r_ov && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov       <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            priority if (r_skid_vld) begin
                if (w_take) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (w_push) begin
                if (w_take || !r_ov) begin
                    r_ov <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (w_take) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_od <= r_skid;
            end
        end else if (w_push) begin
            if (w_take || !r_ov) begin
                r_od <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_res.valid = r_ov;
    assign o_res.data  = r_od;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> !i_pix.ready)
        else $error("pixel accepted while max distance is being computed");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_ov)
        else $error("skid word held with empty output word");

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready) |=> w_stat.busy)
        else $error("register write did not restart geometry");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |=> ($stable(r_s5_vld) && $stable(r_s1_vld)))
        else $error("pipeline moved while skid word was full");

endmodule

>>> tb/sv/tb_top.sv
// self-checking bench for radial_vignette_pixel_core: random and directed pixels,
// frame size changes and handshake stalls, predicted results checked in order
// depends on rvp_pkg, rvp_chan_if and radial_vignette_pixel_core
`timescale 1ns / 1ps

module tb_top;
    import rvp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_PIXELS = 180;

    // expected shaded pixels and the frame size they are computed for
    class vignette_board;
        logic [CFG_W-1:0] frame_w;
        logic [CFG_W-1:0] frame_h;
        t_pix_out shaded_q[$];
        int errors;
        int pixels_in;
        int words_out;

        function new();
            frame_w = WIDTH_RST;
            frame_h = HEIGHT_RST;
            errors = 0;
            pixels_in = 0;
            words_out = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_WIDTH: frame_w = v;
                REG_HEIGHT: frame_h = v;
                default: ;
            endcase
        endfunction

        // floor(sqrt(s) * 256) by digit-by-digit root of s << 16
        function longint unsigned root_q8(longint unsigned s);
            longint unsigned v, acc, b;
            v = s << 16;
            acc = 0;
            b = 64'h1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0) begin
                if (v >= acc + b) begin
                    v -= acc + b;
                    acc = (acc >> 1) + b;
                end else begin
                    acc >>= 1;
                end
                b >>= 2;
            end
            return acc;
        endfunction

        function logic [CH_W-1:0] scale_ch(logic [CH_W-1:0] c, longint unsigned g);
            longint unsigned prod, q, frac;
            prod = 64'(c) * g;
            q = prod >> 16;
            frac = prod & 64'hFFFF;
            if (frac > 64'(GAIN_HALF) || (frac == 64'(GAIN_HALF) && q[0]))
                q++;
            return (q > 64'(CH_MAX)) ? CH_MAX : q[CH_W-1:0];
        endfunction

        function t_pix_out shade_pixel(t_pix_in p);
            longint unsigned cx, cy, dx, dy, maxd, pix_d, gain;
            t_pix_out r;
            cx = 64'(((frame_w > MAX_SIDE_DEF) ? MAX_SIDE_DEF : frame_w) >> 1);
            cy = 64'(((frame_h > MAX_SIDE_DEF) ? MAX_SIDE_DEF : frame_h) >> 1);
            maxd = root_q8(cx * cx + cy * cy);
            if (maxd == 0) begin
                r.blue_out = p.blue_in;
                r.green_out = p.green_in;
                r.red_out = p.red_in;
                return r;
            end
            dx = (64'(p.column) >= cx) ? 64'(p.column) - cx : cx - 64'(p.column);
            dy = (64'(p.row) >= cy) ? 64'(p.row) - cy : cy - 64'(p.row);
            pix_d = root_q8(dx * dx + dy * dy);
            if (pix_d >= maxd) begin
                gain = 0;
            end else begin
                gain = ((maxd - pix_d) << 16) / maxd;
                if (gain > 65535)
                    gain = 65535;
            end
            r.blue_out = scale_ch(p.blue_in, gain);
            r.green_out = scale_ch(p.green_in, gain);
            r.red_out = scale_ch(p.red_in, gain);
            return r;
        endfunction

        function void note_pixel(t_pix_in p);
            shaded_q.insert(shaded_q.size(), shade_pixel(p));
            pixels_in++;
        endfunction

        function void check_pixel(t_pix_out got);
            t_pix_out want;
            words_out++;
            if (shaded_q.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            want = shaded_q.pop_front();
            if (got.blue_out !== want.blue_out) begin
                $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
                errors++;
            end
            if (got.green_out !== want.green_out) begin
                $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
                errors++;
            end
            if (got.red_out !== want.red_out) begin
                $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int cycle_count = 0;
    int frames_set = 0;
    bit src_idle;
    bit snk_idle;
    vignette_board sb;

    rvp_chan_if #(.T(t_cfg)) cfg_ch ();
    rvp_chan_if #(.T(t_pix_in)) pix_ch ();
    rvp_chan_if #(.T(t_pix_out)) res_ch ();

    radial_vignette_pixel_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_pix  (pix_ch),
        .o_res  (res_ch)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int draw_gap(input bit idle_on);
        return idle_on ? $urandom_range(0, 14) : 0;
    endfunction

    function automatic logic [CH_W-1:0] pick_ch();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        else if (r == 1)
            return CH_MAX;
        return CH_W'($urandom_range(0, 255));
    endfunction

    function automatic t_pix_in make_pixel();
        int kind, span_w, span_h, c;
        t_pix_in p;
        span_w = (sb.frame_w > MAX_SIDE_DEF) ? MAX_SIDE_DEF : sb.frame_w;
        span_h = (sb.frame_h > MAX_SIDE_DEF) ? MAX_SIDE_DEF : sb.frame_h;
        if (span_w == 0)
            span_w = MAX_SIDE_DEF;
        if (span_h == 0)
            span_h = MAX_SIDE_DEF;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            p.column = COL_W'($urandom_range(0, span_w - 1));
            p.row = COL_W'($urandom_range(0, span_h - 1));
        end else if (kind < 8) begin
            p.column = COL_W'($urandom_range(0, 4095));
            p.row = COL_W'($urandom_range(0, 4095));
        end else begin
            c = span_w / 2 + $urandom_range(0, 6) - 3;
            p.column = COL_W'((c < 0) ? 0 : c);
            c = span_h / 2 + $urandom_range(0, 6) - 3;
            p.row = COL_W'((c < 0) ? 0 : c);
        end
        p.blue_in = pick_ch();
        p.green_in = pick_ch();
        p.red_in = pick_ch();
        return p;
    endfunction

    // entered and left at a falling edge; valid stays high when the next gap is zero
    task automatic drive_pixel(input t_pix_in p, input int gap);
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.data <= p;
        do @(posedge i_clk); while (!(pix_ch.valid && pix_ch.ready));
        sb.note_pixel(p);
        @(negedge i_clk);
    endtask

    task automatic wait_empty();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.shaded_q.size() != 0);
        @(negedge i_clk);
    endtask

    // frame size changes only with the pipeline empty
    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_empty();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= '{index: REG_WIDTH, value: w};
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        sb.set_reg(REG_WIDTH, w);
        @(negedge i_clk);
        cfg_ch.data <= '{index: REG_HEIGHT, value: h};
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        sb.set_reg(REG_HEIGHT, h);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        frames_set++;
    endtask

    // result side
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = draw_gap(snk_idle);
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            sb.check_pixel(res_ch.data);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [CFG_W-1:0] w, h;
        int ph, n;
        sb = new();
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        pix_ch.valid = 1'b0;
        pix_ch.data = '0;
        res_ch.ready = 1'b0;
        src_idle = 1'b1;
        snk_idle = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset frame 640x480: center, origin, far corner, beyond the radius
        drive_pixel('{column: 320, row: 240, blue_in: 255, green_in: 255, red_in: 255},
                    draw_gap(1));
        drive_pixel('{column: 0, row: 0, blue_in: 255, green_in: 128, red_in: 1}, 0);
        drive_pixel('{column: 639, row: 479, blue_in: 200, green_in: 100, red_in: 50},
                    draw_gap(1));
        drive_pixel('{column: 4095, row: 4095, blue_in: 255, green_in: 255, red_in: 255},
                    0);
        drive_pixel('{column: 0, row: 240, blue_in: 0, green_in: 128, red_in: 255},
                    draw_gap(1));
        drive_pixel('{column: 320, row: 0, blue_in: 170, green_in: 85, red_in: 15}, 0);

        // 8x0 frame: gain of exactly one half gives rounding ties
        set_frame(13'd8, 13'd0);
        drive_pixel('{column: 2, row: 0, blue_in: 255, green_in: 1, red_in: 3}, 0);
        drive_pixel('{column: 6, row: 0, blue_in: 254, green_in: 5, red_in: 7},
                    draw_gap(1));
        drive_pixel('{column: 4, row: 0, blue_in: 255, green_in: 255, red_in: 0}, 0);
        drive_pixel('{column: 0, row: 0, blue_in: 255, green_in: 255, red_in: 255}, 0);
        drive_pixel('{column: 4095, row: 4095, blue_in: 9, green_in: 99, red_in: 199}, 0);

        // zero max distance: pass through
        set_frame(13'd1, 13'd1);
        drive_pixel('{column: 0, row: 0, blue_in: 12, green_in: 34, red_in: 56}, 0);
        drive_pixel('{column: 4095, row: 4095, blue_in: 255, green_in: 0, red_in: 129}, 0);
        set_frame(13'd0, 13'd0);
        drive_pixel('{column: 0, row: 0, blue_in: 255, green_in: 255, red_in: 255}, 0);
        drive_pixel('{column: 2048, row: 17, blue_in: 1, green_in: 2, red_in: 3}, 0);

        // sizes above the limit saturate
        set_frame(13'd8191, 13'd8191);
        drive_pixel('{column: 2048, row: 2048, blue_in: 255, green_in: 128, red_in: 64}, 0);
        drive_pixel('{column: 0, row: 0, blue_in: 255, green_in: 255, red_in: 255}, 0);
        drive_pixel('{column: 4095, row: 4095, blue_in: 255, green_in: 255, red_in: 255},
                    draw_gap(1));
        set_frame(13'd4096, 13'd1);
        drive_pixel('{column: 2048, row: 0, blue_in: 77, green_in: 255, red_in: 0}, 0);
        drive_pixel('{column: 1, row: 4095, blue_in: 255, green_in: 33, red_in: 66}, 0);

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin w = 13'd4096; h = 13'd4096; end
                1: begin w = 13'd2; h = 13'd2; end
                2: begin w = 13'd1; h = 13'd4096; end
                3: begin w = 13'd4096; h = 13'd3; end
                4: begin w = WIDTH_RST; h = HEIGHT_RST; end
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        w = CFG_W'($urandom_range(0, 8191));
                        h = CFG_W'($urandom_range(0, 8191));
                    end else begin
                        w = CFG_W'($urandom_range(1, $urandom_range(0, 1) ? 64 : 4096));
                        h = CFG_W'($urandom_range(1, $urandom_range(0, 1) ? 64 : 4096));
                    end
                end
            endcase
            set_frame(w, h);
            n = $urandom_range(0, 3);
            src_idle = n[0];
            snk_idle = n[1];
            for (n = 0; n < PHASE_PIXELS; n++)
                drive_pixel(make_pixel(), draw_gap(src_idle));
        end

        wait_empty();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.shaded_q.size() != 0) begin
            $error("%0d result words never arrived", sb.shaded_q.size());
            sb.errors++;
        end
        $display("ran %0d pixels over %0d frame size settings with random stalls",
                 sb.pixels_in, frames_set);
        $display("compared %0d result words, %0d field mismatches",
                 sb.words_out, sb.errors);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
hdl/rvp_pkg.sv
hdl/rvp_chan_if.sv
hdl/rvp_geom.sv
hdl/rvp_sqrt_pipe.sv
hdl/radial_vignette_pixel_core.sv
tb/sv/tb_top.sv
